// ----- hw/rtl/stkt_pkg.sv -----
// Shared types and constants for the sorted top-k list with threshold.
// No dependencies; imported by every module of the block.
package stkt_pkg;

    localparam int LIST_DEPTH  = 256;
    localparam int MATE_BOUND  = 32000;

    localparam int MOVE_W      = 15;
    localparam int SCORE_W     = 16;
    localparam int KEEP_W      = 9;
    localparam int MARGIN_W    = 15;
    localparam int COUNT_W     = 9;

    localparam int HELD_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W       = ($clog2(LIST_DEPTH) > KEEP_W) ? $clog2(LIST_DEPTH) : KEEP_W;
    localparam int CNT_W       = (HELD_W > KEEP_W) ? HELD_W : KEEP_W;

    // tap selection is gathered per group of cells, then across groups
    localparam int GROUP       = 16;
    localparam int NGROUP      = (LIST_DEPTH + GROUP - 1) / GROUP;

    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_PAD_W   = OUT_DATA_W - (2 + MOVE_W + 2 * SCORE_W + COUNT_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCORE_MARGIN = 1'b1;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_OFFER = 1'b1;

    localparam logic signed [SCORE_W-1:0] MATE_FLOOR = SCORE_W'(-MATE_BOUND);

    typedef struct packed {
        logic                      valid;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
    } stkt_entry_t;

    typedef struct packed {
        logic        insert;
        logic        clear;
        stkt_entry_t new_entry;
    } stkt_ctrl_t;

endpackage

// ----- hw/rtl/stkt_cell.sv -----
// One slot of the sorted list: holds an entry, keeps it, takes the new
// word or takes its upper neighbor's entry on an insert. Uses stkt_pkg.
module stkt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stkt_pkg::stkt_ctrl_t ctrl,
    input  stkt_pkg::stkt_entry_t prev_entry,
    input  logic                prev_keep,
    input  logic                is_last,
    output stkt_pkg::stkt_entry_t entry,
    output logic                keep
);
    import stkt_pkg::*;

    logic                      valid_reg, valid_next;
    logic [MOVE_W-1:0]         move_reg, move_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;

    // the last slot never keeps: on a full list its entry falls off
    assign keep = valid_reg && !is_last
                  && ($signed(score_reg) >= $signed(ctrl.new_entry.score));

    assign entry.valid = valid_reg;
    assign entry.move  = move_reg;
    assign entry.score = score_reg;

    always_comb
    begin
        valid_next = valid_reg;
        move_next  = move_reg;
        score_next = score_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert && !keep)
        begin
            if (prev_keep)
            begin
                valid_next = 1'b1;
                move_next  = ctrl.new_entry.move;
                score_next = ctrl.new_entry.score;
            end
            else
            begin
                valid_next = prev_entry.valid;
                move_next  = prev_entry.move;
                score_next = prev_entry.score;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        move_reg  <= move_next;
        score_reg <= score_next;
    end

endmodule

// ----- hw/rtl/stkt_chain.sv -----
// Row of list cells plus a registered two-level tap selector that picks
// the score of a chosen slot. Uses stkt_pkg and stkt_cell.
module stkt_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stkt_pkg::stkt_ctrl_t          ctrl,
    input  logic [stkt_pkg::KEEP_W-1:0]   tap_index,
    output stkt_pkg::stkt_entry_t         head,
    output logic signed [stkt_pkg::SCORE_W-1:0] tap_score
);
    import stkt_pkg::*;

    stkt_entry_t ent  [LIST_DEPTH];
    logic        keep [LIST_DEPTH];

    logic [SCORE_W-1:0] group_reg  [NGROUP];
    logic [SCORE_W-1:0] group_next [NGROUP];

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            stkt_entry_t prev_e;
            logic        prev_k;
            if (i == 0)
            begin : g_head
                // nothing sits above the head: it takes the new word when it yields
                assign prev_e = '0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = ent[i-1];
                assign prev_k = keep[i-1];
            end
            stkt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .is_last    (i == LIST_DEPTH - 1),
                .entry      (ent[i]),
                .keep       (keep[i])
            );
        end
    endgenerate

    assign head = ent[0];

    // first level: one slot match per group, AND-OR into a register
    always_comb
    begin
        logic [CMP_W-1:0] want;
        want = CMP_W'(tap_index);
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < LIST_DEPTH)
                begin
                    if (CMP_W'(g * GROUP + j) == want)
                    begin
                        group_next[g] = group_next[g] | ent[g * GROUP + j].score;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_reg[g] <= group_next[g];
        end
    end

    always_comb
    begin
        logic [SCORE_W-1:0] acc;
        acc = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            acc = acc | group_reg[g];
        end
        tap_score = $signed(acc);
    end

endmodule

// ----- hw/rtl/sorted_top_k_with_threshold.sv -----
// Sorted top-k list with acceptance threshold: top level, control and ports.
// Uses stkt_pkg and stkt_chain.
//
// The block keeps up to LIST_DEPTH (move, score) entries sorted by
// descending score in a row of slot cells; an accepted offer is placed at
// once by every cell comparing its score with the offer; each holds, takes
// the new entry or takes its neighbor's entry. Every input word gives
// exactly one result word. A clear or a rejected offer goes from accept to
// the emit state; an inserted offer first passes the gather and finish
// states, as the threshold needs the score at slot keep_count-1 from a
// registered two-level selector across cells or, with fewer entries held,
// the head score less the margin. A finished result sits in the output
// register while the next word is already being taken. Configuration
// writes are accepted every cycle and must only come while idle.
module sorted_top_k_with_threshold (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [14:0] move_code, [30:15] score, [31] zero
    input  logic [stkt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] accepted, [1] overflow, [16:2] best_move, [32:17] best_score,
    // [48:33] threshold, [57:49] entry_count, [63:58] zero
    output logic [stkt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stkt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [stkt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import stkt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [HELD_W-1:0]         held_reg, held_next;
    logic signed [SCORE_W-1:0] thr_reg, thr_next;
    logic                      acc_reg, acc_next;
    logic                      ovf_reg, ovf_next;
    logic [KEEP_W-1:0]         keep_reg;
    logic [MARGIN_W-1:0]       margin_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]     out_data_reg, out_data_next;

    logic                      in_fire;
    logic                      in_req;
    logic [MOVE_W-1:0]         in_move;
    logic signed [SCORE_W-1:0] in_score;
    logic                      wins;
    logic                      full;
    stkt_ctrl_t                ctrl;
    stkt_entry_t               head;
    logic signed [SCORE_W-1:0] tap_score;
    logic [KEEP_W-1:0]         keep_eff;
    logic [KEEP_W-1:0]         tap_index;
    logic signed [SCORE_W:0]   margin_diff;
    logic [MOVE_W-1:0]         best_move;
    logic [SCORE_W-1:0]        best_score;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_move       = s_axis_tdata[MOVE_W-1:0];
    assign in_score      = $signed(s_axis_tdata[MOVE_W+SCORE_W-1:MOVE_W]);
    assign wins          = (in_score > thr_reg);
    assign full          = (held_reg == HELD_W'(LIST_DEPTH));

    assign ctrl.clear               = in_fire && (in_req == REQ_CLEAR);
    assign ctrl.insert              = in_fire && (in_req == REQ_OFFER) && wins;
    assign ctrl.new_entry.valid     = 1'b1;
    assign ctrl.new_entry.move      = in_move;
    assign ctrl.new_entry.score     = in_score;

    // zero keep count behaves as one
    assign keep_eff  = (keep_reg == '0) ? KEEP_W'(1) : keep_reg;
    assign tap_index = keep_eff - KEEP_W'(1);

    stkt_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .tap_index (tap_index),
        .head      (head),
        .tap_score (tap_score)
    );

    assign margin_diff = {head.score[SCORE_W-1], head.score}
                         - $signed({2'b00, margin_reg});

    assign best_move  = (held_reg != '0) ? head.move : '0;
    assign best_score = (held_reg != '0) ? head.score : '0;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg   <= KEEP_W'(1);
            margin_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEEP_COUNT:   keep_reg   <= cfg_data[KEEP_W-1:0];
                REG_SCORE_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        thr_next       = thr_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next = 1'b0;
                    ovf_next = 1'b0;
                    priority if (in_req == REQ_CLEAR)
                    begin
                        held_next  = '0;
                        thr_next   = MATE_FLOOR;
                        state_next = ST_EMIT;
                    end
                    else if (wins)
                    begin
                        acc_next   = 1'b1;
                        ovf_next   = full;
                        held_next  = full ? held_reg : held_reg + HELD_W'(1);
                        state_next = ST_GATHER;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_GATHER:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (CNT_W'(held_reg) >= CNT_W'(keep_eff))
                begin
                    thr_next = tap_score;
                end
                else if (margin_diff < $signed({MATE_FLOOR[SCORE_W-1], MATE_FLOOR}))
                begin
                    thr_next = MATE_FLOOR;
                end
                else
                begin
                    thr_next = margin_diff[SCORE_W-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, COUNT_W'(held_reg), thr_reg,
                                      best_score, best_move, ovf_reg, acc_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            thr_reg       <= MATE_FLOOR;
            acc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            thr_reg       <= thr_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/stkt_checker.sv -----
// Port-level checks for the sorted top-k list, bound to the top level.
// Uses stkt_pkg; sees only the ports of sorted_top_k_with_threshold.
module stkt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [stkt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import stkt_pkg::*;

    // a dropped tail only happens on an inserted offer
    a_ovf_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("overflow without accepted");

    // an empty list reports a zero head
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[57:49] == '0) && !m_axis_tdata[0]
        |-> (m_axis_tdata[32:2] == '0))
        else $error("empty list with nonzero head");

    // threshold never drops below the mate floor
    a_thr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[48:33]) >= MATE_FLOOR))
        else $error("threshold below mate floor");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind sorted_top_k_with_threshold stkt_checker u_stkt_checker (.*);

// ----- bench/stkt_list_checker.sv -----
// Checker for the sorted top-k list: watches the input, result and register
// channels, predicts every result word and compares it field by field.
// Depends on stkt_pkg for widths, register indexes and request codes.
module stkt_list_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [stkt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [stkt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [stkt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stkt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);
    import stkt_pkg::*;

    typedef struct {
        logic                      accepted;
        logic                      overflow;
        logic [MOVE_W-1:0]         best_move;
        logic signed [SCORE_W-1:0] best_score;
        logic signed [SCORE_W-1:0] threshold;
        logic [COUNT_W-1:0]        entry_count;
    } list_status_t;

    // own copy of the ranked list, threshold and registers
    logic [MOVE_W-1:0]         slot_move  [LIST_DEPTH];
    logic signed [SCORE_W-1:0] slot_score [LIST_DEPTH];
    int                        held;
    logic signed [SCORE_W-1:0] level;
    logic [KEEP_W-1:0]         keep_reg;
    logic [MARGIN_W-1:0]       margin_reg;

    list_status_t status_q [$];

    function automatic list_status_t rank_word(input logic req,
                                               input logic [MOVE_W-1:0] mv,
                                               input logic signed [SCORE_W-1:0] sc);
        list_status_t st;
        int pos;
        int k;
        int lowered;
        st.accepted = 1'b0;
        st.overflow = 1'b0;
        if (req == REQ_CLEAR)
        begin
            held  = 0;
            level = MATE_FLOOR;
        end
        else if (sc > level)
        begin
            st.accepted = 1'b1;
            // full list: tail goes, then normal insert
            if (held >= LIST_DEPTH)
            begin
                held        = LIST_DEPTH - 1;
                st.overflow = 1'b1;
            end
            pos = 0;
            while (pos < held && slot_score[pos] >= sc)
                pos++;
            for (int i = held; i > pos; i--)
            begin
                slot_move[i]  = slot_move[i-1];
                slot_score[i] = slot_score[i-1];
            end
            slot_move[pos]  = mv;
            slot_score[pos] = sc;
            held++;
            k = (keep_reg == '0) ? 1 : int'(keep_reg);
            if (held >= k)
                level = slot_score[k-1];
            else
            begin
                lowered = int'(slot_score[0]) - int'(margin_reg);
                level   = (lowered < -MATE_BOUND) ? MATE_FLOOR : SCORE_W'(lowered);
            end
        end
        st.best_move   = (held != 0) ? slot_move[0] : '0;
        st.best_score  = (held != 0) ? slot_score[0] : '0;
        st.threshold   = level;
        st.entry_count = COUNT_W'(held);
        return st;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (fail_count < 40)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_status_t want;
        if (!rst_n)
        begin
            held       = 0;
            level      = MATE_FLOOR;
            keep_reg   = KEEP_W'(1);
            margin_reg = '0;
            status_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results first: an output word always belongs to an older input word
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_q.size() == 0)
                begin
                    if (fail_count < 40)
                        $display("%0t: result word %h with nothing outstanding",
                                 $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("accepted", want.accepted, m_axis_tdata[0]);
                    check_field("overflow", want.overflow, m_axis_tdata[1]);
                    check_field("best_move", want.best_move, m_axis_tdata[16:2]);
                    check_field("best_score", int'(want.best_score),
                                int'($signed(m_axis_tdata[32:17])));
                    check_field("threshold", int'(want.threshold),
                                int'($signed(m_axis_tdata[48:33])));
                    check_field("entry_count", want.entry_count, m_axis_tdata[57:49]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_KEEP_COUNT)
                    keep_reg = cfg_data[KEEP_W-1:0];
                else if (cfg_index == REG_SCORE_MARGIN)
                    margin_reg = cfg_data[MARGIN_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                status_q.push_back(rank_word(s_axis_tuser, s_axis_tdata[14:0],
                                             $signed(s_axis_tdata[30:15])));
            pending = status_q.size();
        end
    end

endmodule

// ----- bench/tb_sorted_top_k_with_threshold.sv -----
// Testbench top for the sorted top-k list: clock, reset, stimulus, random
// back-pressure, watchdog and verdict. Uses stkt_pkg and stkt_list_checker.
module tb_sorted_top_k_with_threshold;
    import stkt_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 85;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int fail_count;
    int pending;
    int ready_hold   = 0;
    int quiet        = 0;
    int words_sent   = 0;
    int send_gap_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_top_k_with_threshold u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stkt_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // result back-pressure
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = gap_cycles();
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 8);
            end
        end
        else
            ready_hold--;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Called and left at a falling edge; valid stays up for a following word.
    task automatic send_word(input logic req, input logic [MOVE_W-1:0] mv,
                             input logic signed [SCORE_W-1:0] sc);
        if ($urandom_range(1, 100) <= send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_cycles()) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, sc, mv};
        s_axis_tuser  <= req;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // Registers only change once every outstanding result has come back.
    task automatic configure(input logic [KEEP_W-1:0] keep, input logic [MARGIN_W-1:0] margin);
        logic [31:0] junk;
        junk = $urandom;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_KEEP_COUNT;
        cfg_data  <= {junk[CFG_DATA_W-KEEP_W-1:0], keep};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= REG_SCORE_MARGIN;
        cfg_data  <= margin;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // clear, then scores walking up or down by random steps
    task automatic ramp_run(input int len, input int start, input int step_max, input bit down);
        int sc;
        int step;
        sc = start;
        send_word(REQ_CLEAR, MOVE_W'($urandom), SCORE_W'($urandom));
        for (int i = 0; i < len; i++)
        begin
            send_word(REQ_OFFER, MOVE_W'($urandom), SCORE_W'(sc));
            step = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4 * step_max + 4)
                                                : $urandom_range(0, step_max);
            sc = down ? sc - step : sc + step;
            if (sc > 32767)
                sc = 32767;
            if (sc < -32768)
                sc = -32768;
        end
    endtask

    task automatic spread_run(input int len, input int base, input int width, input bit noisy);
        logic req;
        if (!noisy)
            send_word(REQ_CLEAR, MOVE_W'($urandom), SCORE_W'($urandom));
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                req = 1'($urandom_range(0, 1));
            else
                req = ($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_OFFER;
            if (width == 0)
                send_word(req, MOVE_W'($urandom), SCORE_W'($urandom));
            else
                send_word(req, MOVE_W'($urandom), SCORE_W'(base + $urandom_range(0, width)));
        end
    endtask

    initial
    begin
        int keep_set   [PHASES];
        int margin_set [PHASES];
        bit long_set   [PHASES];
        int keep;
        int margin;
        int first;
        int kind;
        int len;

        keep_set   = '{1, 256, 2, 511, 16, 0, 257, 5, 255, 64, 0, 0};
        margin_set = '{0, 100, 0, 32767, 500, 1, 32767, 2000, 50, 10, 0, 0};
        long_set   = '{0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset settings: keep one, no margin
        send_word(REQ_OFFER, 15'h7fff, -16'sd32768);
        send_word(REQ_OFFER, 15'h0001, MATE_FLOOR);            // equal to floor: rejected
        send_word(REQ_OFFER, 15'h0000, MATE_FLOOR + 16'sd1);
        send_word(REQ_OFFER, 15'h0002, MATE_FLOOR + 16'sd1);
        send_word(REQ_OFFER, 15'h7fff, 16'sd32767);
        send_word(REQ_OFFER, 15'h0003, 16'sd32767);
        send_word(REQ_CLEAR, 15'h7fff, -16'sd1);
        send_word(REQ_OFFER, 15'h0005, 16'sd0);

        // ties go behind, margin floors at the mate bound
        configure(KEEP_W'(3), MARGIN_W'(32767));
        send_word(REQ_CLEAR, 15'h0000, 16'sd0);
        send_word(REQ_OFFER, 15'd11, 16'sd100);
        send_word(REQ_OFFER, 15'd12, 16'sd100);
        send_word(REQ_OFFER, 15'd13, 16'sd100);
        send_word(REQ_OFFER, 15'd14, 16'sd50);
        send_word(REQ_OFFER, 15'd15, 16'sd200);
        send_word(REQ_OFFER, 15'd16, 16'sd100);

        // keep count zero acts as one
        configure(KEEP_W'(0), MARGIN_W'(0));
        send_word(REQ_CLEAR, 15'h0000, 16'sd0);
        send_word(REQ_OFFER, 15'd21, 16'sd10);
        send_word(REQ_OFFER, 15'd22, 16'sd5);
        send_word(REQ_OFFER, 15'd23, 16'sd20);
        send_word(REQ_OFFER, 15'd24, -16'sd32768);

        for (int p = 0; p < PHASES; p++)
        begin
            keep   = (p >= 10) ? $urandom_range(0, 511) : keep_set[p];
            margin = (p >= 10) ? $urandom_range(0, 32767) : margin_set[p];
            configure(KEEP_W'(keep), MARGIN_W'(margin));
            first = words_sent;
            // long rising run fills the list and overflows it
            if (long_set[p])
            begin
                send_gap_pct = $urandom_range(0, 1) * 20;
                ramp_run($urandom_range(260, 300), -31000, 150, 1'b0);
            end
            while (words_sent - first < PHASE_WORDS)
            begin
                case ($urandom_range(0, 2))
                    0:       send_gap_pct = 0;
                    1:       send_gap_pct = 15;
                    default: send_gap_pct = 50;
                endcase
                kind = $urandom_range(0, 9);
                len  = $urandom_range(1, 40);
                if (kind <= 3)
                    ramp_run(len, $urandom_range(0, 52000) - 31990, $urandom_range(0, 8), 1'b0);
                else if (kind <= 5)
                    ramp_run(len, $urandom_range(0, 62000) - 30000, $urandom_range(0, 300),
                             1'b1);
                else if (kind <= 7)
                    spread_run(len, 0, 0, 1'b0);
                else if (kind == 8)
                    spread_run(len, $urandom_range(0, 60000) - 30000, 20, 1'b0);
                else
                    spread_run(len, 0, 0, 1'b1);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
